// ===== src/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, widths and operation codes of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;

   localparam int PROD_W = 2 * DATA_WIDTH;
   localparam int NUM_W  = PROD_W + 1;
   localparam int MAG_W  = PROD_W;
   localparam int QUO_W  = DATA_WIDTH + 1;
   localparam int REM_W  = MAG_W + FRAC_BITS;
   localparam int CMP_W  = MAG_W + FRAC_BITS + QUO_W;
   localparam int FIN_W  = MAG_W + 1;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_DIV = 2'd3;

   typedef struct packed {
      logic [1:0]                   cmd;
      logic signed [DATA_WIDTH-1:0] a_re;
      logic signed [DATA_WIDTH-1:0] a_im;
      logic signed [DATA_WIDTH-1:0] b_re;
      logic signed [DATA_WIDTH-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] res_re;
      logic signed [DATA_WIDTH-1:0] res_im;
      logic                         div_zero;
      logic                         overflow;
   } rsp_type;

   typedef struct packed {
      logic                  neg;
      logic                  big;
      logic [REM_W-1:0]      rem;
      logic [QUO_W-1:0]      quo;
      logic [MAG_W-1:0]      mag;
   } part_type;

   // saturate a sign and magnitude pair to the signed data range
   function automatic logic [DATA_WIDTH:0] saturate(input logic neg,
                                                    input logic [FIN_W-1:0] mag);
      logic [FIN_W-1:0]      lim_neg;
      logic [FIN_W-1:0]      lim_pos;
      logic [FIN_W-1:0]      m;
      logic                  ovf;
      logic [FIN_W-1:0]      v;
      lim_neg = FIN_W'(1) << (DATA_WIDTH - 1);
      lim_pos = lim_neg - FIN_W'(1);
      m       = mag;
      ovf     = 1'b0;
      if (neg) begin
         if (m > lim_neg) begin
            m   = lim_neg;
            ovf = 1'b1;
         end
         v = -m;
      end else begin
         if (m > lim_pos) begin
            m   = lim_pos;
            ovf = 1'b1;
         end
         v = m;
      end
      return {ovf, v[DATA_WIDTH-1:0]};
   endfunction

endpackage

`default_nettype wire

// ===== src/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex add, subtract, multiply and divide on signed Q8.8 parts,
// with saturation and a divide-by-zero flag.
// ----------------------------------------------------------------------------
//   channel   ports                      direction   content
//   request   req_valid/req_stall/req_data   in       command and operands a, b
//   response  rsp_valid/rsp_stall/rsp_data   out      result parts and flags
//
// Stages in order: products, combine, divide setup, one restoring quotient bit
// per stage, then saturation into the output stage. One transaction enters
// per cycle unless req_stall is set; every operation walks the full pipeline.
// Reset clears the stage valid bits only. A stall at the output holds the
// output stage; earlier stages keep filling bubbles until the pipe is full.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire cau_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      cau_pkg::rsp_type rsp_data
);

   localparam int DW = cau_pkg::DATA_WIDTH;
   localparam int QW = cau_pkg::QUO_W;
   localparam int NS = QW + 4;

   typedef struct packed {
      logic [1:0]                         cmd;
      logic signed [cau_pkg::PROD_W-1:0]  rr;
      logic signed [cau_pkg::PROD_W-1:0]  ii;
      logic signed [cau_pkg::PROD_W-1:0]  ri;
      logic signed [cau_pkg::PROD_W-1:0]  ir;
      logic [cau_pkg::PROD_W-1:0]         brr;
      logic [cau_pkg::PROD_W-1:0]         bii;
      logic signed [DW:0]                 sum_re;
      logic signed [DW:0]                 sum_im;
   } s1_type;

   typedef struct packed {
      logic [1:0]                  cmd;
      logic                        re_neg;
      logic [cau_pkg::MAG_W-1:0]   re_mag;
      logic                        im_neg;
      logic [cau_pkg::MAG_W-1:0]   im_mag;
      logic [cau_pkg::MAG_W-1:0]   dsor;
   } s2_type;

   typedef struct packed {
      logic [1:0]                  cmd;
      logic                        dz;
      logic [cau_pkg::MAG_W-1:0]   dsor;
      cau_pkg::part_type           re;
      cau_pkg::part_type           im;
   } dv_type;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] move;

   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   dv_type  dv_ff [0:QW];
   dv_type  dv_in [0:QW];
   cau_pkg::rsp_type out_ff, out_in;

   always_comb begin
      move[NS-1] = !vld_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         move[k] = !vld_ff[k] || move[k+1];
      end
   end

   assign req_stall = !move[0];
   assign rsp_valid = vld_ff[NS-1];
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (move[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (move[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // stage 1: products and sums
   always_comb begin
      logic signed [DW:0] ar, ai, br, bi;
      ar = {req_data.a_re[DW-1], req_data.a_re};
      ai = {req_data.a_im[DW-1], req_data.a_im};
      br = {req_data.b_re[DW-1], req_data.b_re};
      bi = {req_data.b_im[DW-1], req_data.b_im};
      s1_in.cmd = req_data.cmd;
      s1_in.rr  = cau_pkg::PROD_W'(req_data.a_re) * cau_pkg::PROD_W'(req_data.b_re);
      s1_in.ii  = cau_pkg::PROD_W'(req_data.a_im) * cau_pkg::PROD_W'(req_data.b_im);
      s1_in.ri  = cau_pkg::PROD_W'(req_data.a_re) * cau_pkg::PROD_W'(req_data.b_im);
      s1_in.ir  = cau_pkg::PROD_W'(req_data.a_im) * cau_pkg::PROD_W'(req_data.b_re);
      s1_in.brr = cau_pkg::PROD_W'(req_data.b_re) * cau_pkg::PROD_W'(req_data.b_re);
      s1_in.bii = cau_pkg::PROD_W'(req_data.b_im) * cau_pkg::PROD_W'(req_data.b_im);
      if (req_data.cmd == cau_pkg::CMD_SUB) begin
         s1_in.sum_re = ar - br;
         s1_in.sum_im = ai - bi;
      end else begin
         s1_in.sum_re = ar + br;
         s1_in.sum_im = ai + bi;
      end
   end

   // stage 2: combine to sign and magnitude, form divisor
   always_comb begin
      logic signed [cau_pkg::NUM_W-1:0] nre, nim, mre, mim;
      case (s1_ff.cmd)
         cau_pkg::CMD_MUL: begin
            nre = cau_pkg::NUM_W'(s1_ff.rr) - cau_pkg::NUM_W'(s1_ff.ii);
            nim = cau_pkg::NUM_W'(s1_ff.ri) + cau_pkg::NUM_W'(s1_ff.ir);
         end
         cau_pkg::CMD_DIV: begin
            nre = cau_pkg::NUM_W'(s1_ff.rr) + cau_pkg::NUM_W'(s1_ff.ii);
            nim = cau_pkg::NUM_W'(s1_ff.ir) - cau_pkg::NUM_W'(s1_ff.ri);
         end
         default: begin
            nre = cau_pkg::NUM_W'(s1_ff.sum_re);
            nim = cau_pkg::NUM_W'(s1_ff.sum_im);
         end
      endcase
      mre = -nre;
      mim = -nim;
      s2_in.cmd    = s1_ff.cmd;
      s2_in.re_neg = nre[cau_pkg::NUM_W-1];
      s2_in.im_neg = nim[cau_pkg::NUM_W-1];
      s2_in.re_mag = nre[cau_pkg::NUM_W-1] ? mre[cau_pkg::MAG_W-1:0] : nre[cau_pkg::MAG_W-1:0];
      s2_in.im_mag = nim[cau_pkg::NUM_W-1] ? mim[cau_pkg::MAG_W-1:0] : nim[cau_pkg::MAG_W-1:0];
      s2_in.dsor   = s1_ff.brr + s1_ff.bii;
   end

   // stage 3: divide setup and fraction shift for multiply
   always_comb begin
      logic [cau_pkg::CMP_W-1:0] dlim;
      logic [cau_pkg::CMP_W-1:0] dsh;
      dlim = cau_pkg::CMP_W'(s2_ff.dsor) << QW;
      dv_in[0].cmd    = s2_ff.cmd;
      dv_in[0].dz     = (s2_ff.dsor == '0);
      dv_in[0].dsor   = s2_ff.dsor;
      dv_in[0].re.neg = s2_ff.re_neg;
      dv_in[0].im.neg = s2_ff.im_neg;
      dv_in[0].re.rem = cau_pkg::REM_W'(s2_ff.re_mag) << cau_pkg::FRAC_BITS;
      dv_in[0].im.rem = cau_pkg::REM_W'(s2_ff.im_mag) << cau_pkg::FRAC_BITS;
      dv_in[0].re.big = (cau_pkg::CMP_W'(dv_in[0].re.rem) >= dlim);
      dv_in[0].im.big = (cau_pkg::CMP_W'(dv_in[0].im.rem) >= dlim);
      dv_in[0].re.quo = '0;
      dv_in[0].im.quo = '0;
      if (s2_ff.cmd == cau_pkg::CMD_MUL) begin
         dv_in[0].re.mag = s2_ff.re_mag >> cau_pkg::FRAC_BITS;
         dv_in[0].im.mag = s2_ff.im_mag >> cau_pkg::FRAC_BITS;
      end else begin
         dv_in[0].re.mag = s2_ff.re_mag;
         dv_in[0].im.mag = s2_ff.im_mag;
      end

      // restoring divide: one quotient bit per stage
      for (int k = 1; k <= QW; k++) begin
         dsh      = cau_pkg::CMP_W'(dv_ff[k-1].dsor) << (QW - k);
         dv_in[k] = dv_ff[k-1];
         if (cau_pkg::CMP_W'(dv_ff[k-1].re.rem) >= dsh) begin
            dv_in[k].re.rem = dv_ff[k-1].re.rem - dsh[cau_pkg::REM_W-1:0];
            dv_in[k].re.quo[QW-k] = 1'b1;
         end
         if (cau_pkg::CMP_W'(dv_ff[k-1].im.rem) >= dsh) begin
            dv_in[k].im.rem = dv_ff[k-1].im.rem - dsh[cau_pkg::REM_W-1:0];
            dv_in[k].im.quo[QW-k] = 1'b1;
         end
      end
   end

   // output stage: select magnitude and saturate
   always_comb begin
      logic [cau_pkg::FIN_W-1:0] fre, fim;
      logic [DW:0]               sre, sim;
      if (dv_ff[QW].cmd == cau_pkg::CMD_DIV) begin
         if (dv_ff[QW].dz) begin
            fre = '0;
            fim = '0;
         end else begin
            fre = dv_ff[QW].re.big ? (cau_pkg::FIN_W'(1) << QW)
                                   : cau_pkg::FIN_W'(dv_ff[QW].re.quo);
            fim = dv_ff[QW].im.big ? (cau_pkg::FIN_W'(1) << QW)
                                   : cau_pkg::FIN_W'(dv_ff[QW].im.quo);
         end
      end else begin
         fre = cau_pkg::FIN_W'(dv_ff[QW].re.mag);
         fim = cau_pkg::FIN_W'(dv_ff[QW].im.mag);
      end
      sre = cau_pkg::saturate(dv_ff[QW].re.neg, fre);
      sim = cau_pkg::saturate(dv_ff[QW].im.neg, fim);
      out_in.res_re   = sre[DW-1:0];
      out_in.res_im   = sim[DW-1:0];
      out_in.div_zero = (dv_ff[QW].cmd == cau_pkg::CMD_DIV) && dv_ff[QW].dz;
      out_in.overflow = sre[DW] || sim[DW];
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         s1_ff <= s1_in;
      end
      if (move[1]) begin
         s2_ff <= s2_in;
      end
      for (int k = 0; k <= QW; k++) begin
         if (move[k+2]) begin
            dv_ff[k] <= dv_in[k];
         end
      end
      if (move[NS-1]) begin
         out_ff <= out_in;
      end
   end

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.div_zero && rsp_data.overflow))
      else $error("div_zero and overflow both set");

   a_div_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_zero |-> rsp_data.res_re == '0 && rsp_data.res_im == '0)
      else $error("divide by zero gave nonzero result");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && (&vld_ff))
      else $error("input stalled with room in the pipeline");

   a_advance_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !(&vld_ff) || !$stable(rsp_data) || rsp_valid)
      else $error("output stage failed to advance");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the complex arithmetic unit against a bit-accurate predictor of add,
// subtract, complex multiply and divide with saturation and divide-by-zero,
// under random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   localparam int LATENCY = cau_pkg::QUO_W + 4;
   localparam int LIMIT   = 400000;
   localparam int DW      = cau_pkg::DATA_WIDTH;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   cau_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   cau_pkg::rsp_type rsp_data;

   cau_pkg::req_type pending_q[$];
   cau_pkg::rsp_type expected_q[$];
   int      mismatches;
   int      cycle;
   int      idle_in;
   int      idle_out;
   int      holdoff;
   bit      holdoff_armed;
   bit      quiet;
   bit      req_taken;

   complex_arith_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // truncating scaled quotient, capped above the saturation range
   function automatic longint scaled_quotient(longint n, longint d);
      longint q;
      longint cap;
      cap = longint'(1) << DW;
      if (n < 0) n = -n;
      q = (n << cau_pkg::FRAC_BITS) / d;
      return (q > cap) ? cap : q;
   endfunction

   function automatic logic [DW:0] clamp(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (DW - 1)) - 1;
      lo = -(longint'(1) << (DW - 1));
      if (v > hi) return {1'b1, DW'(hi)};
      if (v < lo) return {1'b1, DW'(lo)};
      return {1'b0, DW'(v)};
   endfunction

   function automatic cau_pkg::rsp_type complex_result(cau_pkg::req_type t);
      longint ar, ai, br, bi, re, im, d, nr, ni;
      logic [DW:0] cr, ci;
      cau_pkg::rsp_type r;
      ar = t.a_re; ai = t.a_im; br = t.b_re; bi = t.b_im;
      r = '0;
      case (t.cmd)
         cau_pkg::CMD_ADD: begin re = ar + br; im = ai + bi; end
         cau_pkg::CMD_SUB: begin re = ar - br; im = ai - bi; end
         cau_pkg::CMD_MUL: begin
            nr = ar * br - ai * bi;
            ni = ar * bi + ai * br;
            re = (nr < 0) ? -((-nr) >>> cau_pkg::FRAC_BITS) : (nr >>> cau_pkg::FRAC_BITS);
            im = (ni < 0) ? -((-ni) >>> cau_pkg::FRAC_BITS) : (ni >>> cau_pkg::FRAC_BITS);
         end
         default: begin
            d = br * br + bi * bi;
            if (d == 0) begin
               r.div_zero = 1'b1;
               return r;
            end
            nr = ar * br + ai * bi;
            ni = ai * br - ar * bi;
            re = scaled_quotient(nr, d);
            im = scaled_quotient(ni, d);
            if (nr < 0) re = -re;
            if (ni < 0) im = -im;
         end
      endcase
      cr = clamp(re);
      ci = clamp(im);
      r.res_re   = cr[DW-1:0];
      r.res_im   = ci[DW-1:0];
      r.overflow = cr[DW] | ci[DW];
      return r;
   endfunction

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 15)) - 16'd8;
         4: return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_item(logic [1:0] cmd, logic [15:0] ar, logic [15:0] ai,
                           logic [15:0] br, logic [15:0] bi);
      cau_pkg::req_type t;
      t.cmd = cmd; t.a_re = ar; t.a_im = ai; t.b_re = br; t.b_im = bi;
      pending_q.push_back(t);
   endtask

   initial begin
      logic [1:0] c;
      reset = 1'b1;
      for (int i = 0; i < 4; i++) begin
         c = 2'(i);
         add_item(c, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
         add_item(c, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
         add_item(c, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
         add_item(c, 16'h0100, 16'hff00, 16'h0001, 16'h0000);
         add_item(c, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      end
      add_item(cau_pkg::CMD_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
      add_item(cau_pkg::CMD_DIV, 16'h0300, 16'hfd00, 16'h0000, 16'h0200);
      add_item(cau_pkg::CMD_DIV, 16'hffff, 16'h0001, 16'h0100, 16'h0000);
      add_item(cau_pkg::CMD_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
      for (int i = 0; i < 1600; i++)
         add_item(2'($urandom_range(0, 3)), pick_value(), pick_value(),
                  pick_value(), pick_value());
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // record whether the offered transaction was taken at the rising edge
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         idle_in   <= 0;
      end else if (!req_valid || req_taken) begin
         if (req_valid) void'(pending_q.pop_front());
         if (idle_in > 0) begin
            req_valid <= 1'b0;
            idle_in   <= idle_in - 1;
         end else if (pending_q.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_q[0];
            if (!quiet && $urandom_range(0, 7) == 0) idle_in <= $urandom_range(1, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall     <= 1'b0;
         idle_out      <= 0;
         holdoff       <= 0;
         holdoff_armed <= 1'b1;
      end else if (holdoff_armed && pending_q.size() < 1200) begin
         holdoff_armed <= 1'b0;
         holdoff       <= 200;
         rsp_stall     <= 1'b1;
      end else if (holdoff > 0) begin
         holdoff   <= holdoff - 1;
         rsp_stall <= holdoff > 1;
      end else if (idle_out > 0) begin
         idle_out  <= idle_out - 1;
         rsp_stall <= idle_out > 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         idle_out  <= $urandom_range(1, 13);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      cau_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) expected_q.push_back(complex_result(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected transaction %p", rsp_data);
            end else begin
               want = expected_q.pop_front();
               if (want.res_re !== rsp_data.res_re || want.res_im !== rsp_data.res_im ||
                   want.div_zero !== rsp_data.div_zero ||
                   want.overflow !== rsp_data.overflow) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: expected %p actual %p", want, rsp_data);
               end
            end
         end
      end
   end

   initial begin
      mismatches = 0;
      cycle      = 0;
      quiet      = 1'b0;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (!reset && pending_q.size() < 200) quiet <= 1'b1;
      if (cycle > LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      wait (!reset);
      wait (pending_q.size() == 0 && !req_valid);
      wait (expected_q.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
